// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, opcodes and field positions for the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Command opcodes carried in s_axis_tuser.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_STOP    = 3'd5;

    // Register byte addresses.
    localparam logic [2:0] ADDR_CLOCK_DIVIDER = 3'd0;
    localparam logic [7:0] CLOCK_DIVIDER_RESET = 8'd39;

    // Bit positions in the result item.
    localparam int OUT_SCL      = 0;
    localparam int OUT_SDA      = 1;
    localparam int OUT_BUSY     = 2;
    localparam int OUT_DONE     = 3;
    localparam int OUT_ACK      = 4;
    localparam int OUT_RDATA_LO = 5;
    localparam int OUT_REJECTED = 13;
    localparam int OUT_WIDTH    = 16;

    localparam int IN_WIDTH = 24;

    // Bus sequencer phases.
    typedef enum logic [10:0] {
        PH_IDLE      = 11'b000_0000_0001,
        PH_RS_PRE    = 11'b000_0000_0010,
        PH_START_HI  = 11'b000_0000_0100,
        PH_START_LOW = 11'b000_0000_1000,
        PH_WR_LOW    = 11'b000_0001_0000,
        PH_WR_HIGH   = 11'b000_0010_0000,
        PH_RD_LOW    = 11'b000_0100_0000,
        PH_RD_HIGH   = 11'b000_1000_0000,
        PH_STOP_A    = 11'b001_0000_0000,
        PH_STOP_B    = 11'b010_0000_0000,
        PH_STOP_C    = 11'b100_0000_0000
    } phase_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level I2C master: start, repeated start, write byte with ACK sample,
// read byte with driven ACK, and stop, paced by a programmable phase length.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: op; tdata: address, rnw, write byte, ack, sda
//  m_axis    out        tdata: scl, sda, busy, done, ack status, read byte, reject
//  apb       in/out     clock_divider at byte address 0
//
//  An item can be accepted on every cycle unless m_axis is stalled.
//  The bus state advances only on accepted items; each SCL phase lasts
//  clock_divider+1 items.
//  rst_n clears the sequencer to idle with both lines released, divider 39.
//  A result waiting on m_axis stalls s_axis only if m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [6:0] target_address, [7] read_not_write, [15:8] write_data,
    // [16] ack_to_send, [17] sda_in, [23:18] zero
    input  wire logic [IN_WIDTH-1:0]  s_axis_tdata,
    // [2:0] op
    input  wire logic [2:0]           s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_status,
    // [12:5] read_data, [13] rejected, [15:14] zero
    output logic [OUT_WIDTH-1:0]      m_axis_tdata,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // Input fields.
    logic [2:0] op;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_in;

    assign op             = s_axis_tuser;
    assign target_address = s_axis_tdata[6:0];
    assign read_not_write = s_axis_tdata[7];
    assign write_data     = s_axis_tdata[15:8];
    assign ack_to_send    = s_axis_tdata[16];
    assign sda_in         = s_axis_tdata[17];

    // Configuration.
    logic [DIVIDER_WIDTH-1:0] clock_divider_reg;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ADDR_CLOCK_DIVIDER[2]);
    assign prdata    = (paddr[2] == ADDR_CLOCK_DIVIDER[2])
                       ? 32'(clock_divider_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_divider_reg <= DIVIDER_WIDTH'(CLOCK_DIVIDER_RESET);
        end
        else if (cfg_write)
        begin
            clock_divider_reg <= DIVIDER_WIDTH'(pwdata[7:0]);
        end
    end

    // Sequencer state.
    phase_t                   phase_reg, phase_next;
    logic [3:0]               bit_count_reg, bit_count_next;
    logic [DIVIDER_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [8:0]               shift_reg_reg, shift_reg_next;
    logic                     ack_latch_reg, ack_latch_next;
    logic [7:0]               received_byte_reg, received_byte_next;
    logic                     ack_drive_bit_reg, ack_drive_bit_next;
    logic                     scl_level_reg, scl_level_next;
    logic                     sda_level_reg, sda_level_next;

    logic       is_cmd;
    logic       do_advance;
    logic       entered;
    logic       done;
    logic       rej;
    logic [3:0] slot_clamp;
    logic [3:0] slot_idx;

    logic                 accept;
    logic                 m_valid_reg;
    logic [OUT_WIDTH-1:0] m_data_reg;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        tick_count_next    = tick_count_reg;
        shift_reg_next     = shift_reg_reg;
        ack_latch_next     = ack_latch_reg;
        received_byte_next = received_byte_reg;
        ack_drive_bit_next = ack_drive_bit_reg;
        scl_level_next     = scl_level_reg;
        sda_level_next     = sda_level_reg;
        entered            = 1'b0;
        done               = 1'b0;
        rej                = 1'b0;
        slot_clamp         = 4'd0;
        slot_idx           = 4'd0;

        is_cmd     = op inside {[OP_START:OP_STOP]};
        do_advance = !(is_cmd && (phase_reg == PH_IDLE));

        if (is_cmd && (phase_reg != PH_IDLE))
        begin
            rej = 1'b1;
        end
        else if (is_cmd)
        begin
            entered = 1'b1;
            bit_count_next = 4'd0;
            case (op)
                OP_START, OP_RESTART:
                begin
                    shift_reg_next = {target_address,
                                      (op == OP_RESTART) ? 1'b1 : read_not_write,
                                      1'b1};
                    phase_next = scl_level_reg ? PH_START_HI : PH_RS_PRE;
                end
                OP_WRITE:
                begin
                    shift_reg_next = {write_data, 1'b1};
                    phase_next     = PH_WR_LOW;
                end
                OP_READ:
                begin
                    ack_drive_bit_next = ack_to_send;
                    shift_reg_next     = 9'd0;
                    phase_next         = PH_RD_LOW;
                end
                default:
                begin
                    phase_next = PH_STOP_A;
                end
            endcase
        end

        if (do_advance && (phase_reg != PH_IDLE))
        begin
            if (tick_count_reg < clock_divider_reg)
            begin
                tick_count_next = tick_count_reg + 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_RS_PRE:
                    begin
                        phase_next = PH_START_HI;
                        entered    = 1'b1;
                    end
                    PH_START_HI:
                    begin
                        phase_next = PH_START_LOW;
                        entered    = 1'b1;
                    end
                    PH_START_LOW:
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = PH_WR_LOW;
                        entered        = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HIGH;
                        entered    = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_HIGH;
                        entered    = 1'b1;
                    end
                    PH_WR_HIGH:
                    begin
                        if (bit_count_reg >= 4'd8)
                        begin
                            ack_latch_next  = sda_in;
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                            bit_count_next  = 4'd0;
                            scl_level_next  = 1'b0;
                            done            = 1'b1;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 4'd1;
                            phase_next     = PH_WR_LOW;
                            entered        = 1'b1;
                        end
                    end
                    PH_RD_HIGH:
                    begin
                        if (bit_count_reg >= 4'd8)
                        begin
                            received_byte_next = shift_reg_reg[7:0];
                            phase_next         = PH_IDLE;
                            tick_count_next    = '0;
                            bit_count_next     = 4'd0;
                            scl_level_next     = 1'b0;
                            done               = 1'b1;
                        end
                        else
                        begin
                            shift_reg_next = {shift_reg_reg[7:0], sda_in};
                            bit_count_next = bit_count_reg + 4'd1;
                            phase_next     = PH_RD_LOW;
                            entered        = 1'b1;
                        end
                    end
                    PH_STOP_A:
                    begin
                        phase_next = PH_STOP_B;
                        entered    = 1'b1;
                    end
                    PH_STOP_B:
                    begin
                        phase_next = PH_STOP_C;
                        entered    = 1'b1;
                    end
                    PH_STOP_C:
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = '0;
                        bit_count_next  = 4'd0;
                        scl_level_next  = 1'b1;
                        sda_level_next  = 1'b1;
                        done            = 1'b1;
                    end
                    default:
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = '0;
                        bit_count_next  = 4'd0;
                    end
                endcase
            end
        end

        // The bit driven in a low phase follows the updated bit count and shifter.
        slot_clamp = (bit_count_next > 4'd8) ? 4'd8 : bit_count_next;
        slot_idx   = 4'd8 - slot_clamp;

        if (entered)
        begin
            tick_count_next = '0;
            case (phase_next)
                PH_RS_PRE:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b1;
                end
                PH_START_HI, PH_STOP_C:
                begin
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b1;
                end
                PH_START_LOW, PH_STOP_B:
                begin
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b0;
                end
                PH_WR_LOW:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = shift_reg_next[slot_idx];
                end
                PH_RD_LOW:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = (slot_clamp < 4'd8) ? 1'b1 : ack_drive_bit_next;
                end
                PH_WR_HIGH, PH_RD_HIGH:
                begin
                    scl_level_next = 1'b1;
                end
                PH_STOP_A:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b0;
                end
                default:
                begin
                    scl_level_next = scl_level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= 4'd0;
            tick_count_reg    <= '0;
            shift_reg_reg     <= 9'd0;
            ack_latch_reg     <= 1'b0;
            received_byte_reg <= 8'd0;
            ack_drive_bit_reg <= 1'b0;
            scl_level_reg     <= 1'b1;
            sda_level_reg     <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            tick_count_reg    <= tick_count_next;
            shift_reg_reg     <= shift_reg_next;
            ack_latch_reg     <= ack_latch_next;
            received_byte_reg <= received_byte_next;
            ack_drive_bit_reg <= ack_drive_bit_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {2'b00, rej, received_byte_next, ack_latch_next, done,
                           (phase_next != PH_IDLE), sda_level_next, scl_level_next};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker
    import i2cm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [OUT_WIDTH-1:0] m_axis_tdata
);

    // A finished command leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DONE] |-> !m_axis_tdata[OUT_BUSY])
        else $error("done reported while still busy");

    // A refused command only happens while a command runs, which either goes on
    // or finishes on that same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_REJECTED]
        |-> m_axis_tdata[OUT_BUSY] || m_axis_tdata[OUT_DONE])
        else $error("rejected item without a running command");

    // The input side stalls only behind a result that is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // A waiting result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
